### hdl/sparse_octree_voxel_store_unit_assert.svh
// Assertion macros for the sparse octree voxel store.
// Included by the modules that carry assertions; no other dependencies.
`ifndef SPARSE_OCTREE_VOXEL_STORE_UNIT_ASSERT_SVH
`define SPARSE_OCTREE_VOXEL_STORE_UNIT_ASSERT_SVH
`define SOVS_ASSERT_IMPL(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SOVS_ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### hdl/sovs_pkg.sv
// Package for the sparse octree voxel store: types, codes and constants.
// No dependencies.
package sovs_pkg;
  localparam int unsigned NodeCountDef = 1024;
  localparam int unsigned MaxLevelsDef = 16;
  localparam int unsigned FracBitsDef  = 16;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_NULL   = 2'd0,
    SLOT_BRANCH = 2'd1,
    SLOT_LEAF   = 2'd2,
    SLOT_RSVD   = 2'd3
  } slot_e;

  typedef enum logic [2:0] {
    CFG_CX = 3'd0, CFG_CY = 3'd1, CFG_CZ = 3'd2,
    CFG_EX = 3'd3, CFG_EY = 3'd4, CFG_EZ = 3'd5,
    CFG_DEPTH = 3'd6, CFG_EMPTY = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_WAIT, BK_DECIDE, BK_FILL, BK_LINK, BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        oob;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] val;
  } cmd_t;
endpackage

### hdl/sovs_front.sv
// Front end: accepts items, classifies bounds and queues commands.
// Depends on sovs_pkg.
module sovs_front import sovs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] store_value_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] cz_i,
  input  logic [30:0]       ex_i,
  input  logic [30:0]       ey_i,
  input  logic [30:0]       ez_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);
  cmd_t       q_mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       oob;
  logic       push, pop;

  function automatic logic axis_out(input logic signed [31:0] p,
                                    input logic signed [31:0] c,
                                    input logic [30:0] e);
    logic signed [33:0] d;
    logic signed [33:0] h;
    d = 34'(p) - 34'(c);
    h = {4'd0, e[30:1]};
    return (d > h) || (d < -h);
  endfunction

  assign oob = axis_out(pos_x_i, cx_i, ex_i) | axis_out(pos_y_i, cy_i, ey_i)
             | axis_out(pos_z_i, cz_i, ez_i);
  assign in_ready    = cnt_q != 2'd2;
  assign push        = in_valid && in_ready;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= '{kind: kind_i, oob: oob, px: pos_x_i, py: pos_y_i,
                         pz: pos_z_i, val: store_value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

### hdl/sovs_back.sv
// Back end: walks the octree in the child store and produces results.
// Depends on sovs_pkg and the assertion macro header.
`include "sparse_octree_voxel_store_unit_assert.svh"
module sovs_back import sovs_pkg::*; #(
  parameter int unsigned NodeCount = NodeCountDef,
  parameter int unsigned MaxLevels = MaxLevelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] cz_i,
  input  logic [30:0]       ex_i,
  input  logic [30:0]       ey_i,
  input  logic [30:0]       ez_i,
  input  logic [4:0]        depth_i,
  input  logic signed [31:0] empty_i,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [31:0] read_value_o,
  output logic [1:0]        status_o
);
  localparam int unsigned NodeW = (NodeCount > 1) ? $clog2(NodeCount) : 1;
  localparam int unsigned CntW  = $clog2(NodeCount + 1);
  localparam int unsigned AddrW = NodeW + 3;
  localparam int unsigned LvlW  = $clog2(MaxLevels + 2);

  logic [33:0] mem_q [NodeCount*8];
  logic [33:0] rd_q;
  logic [7:0]  root_vld_q;

  bk_state_e   st_q, st_d;
  cmd_t        c_q;
  logic signed [33:0] cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  logic [30:0] hx_q, hy_q, hz_q;
  logic [NodeW-1:0] node_q, node_d;
  logic [2:0]  oct_q, oct_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [4:0]  lim;
  logic [CntW-1:0] free_q, free_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic [1:0]  fkind_q, fkind_d;
  logic [31:0] fdata_q, fdata_d;
  logic signed [31:0] rv_q, rv_d;
  logic [1:0]  rs_q, rs_d;
  logic        ov_q;

  logic        we;
  logic [AddrW-1:0] wa, ra;
  logic [33:0] wd;
  logic [1:0]  rkind;
  logic [31:0] rdata;
  logic        node_oob;
  logic        accept;
  logic        root_clr;

  assign lim = (depth_i == 5'd0) ? 5'd1 :
               (32'(depth_i) > MaxLevels) ? 5'(MaxLevels) : depth_i;
  assign ra  = {node_q, oct_q};
  assign rkind = (node_q == '0 && !root_vld_q[oct_q]) ? SLOT_NULL : rd_q[33:32];
  assign rdata = rd_q[31:0];
  assign node_oob = 32'(node_q) >= NodeCount;
  assign accept = (st_q == BK_IDLE) && cmd_valid_i && !ov_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  always_comb begin
    logic signed [33:0] hx2, hy2, hz2;
    logic bx, by, bz;
    st_d = st_q; node_d = node_q; oct_d = oct_q; lvl_d = lvl_q;
    free_d = free_q; fcnt_d = fcnt_q; fkind_d = fkind_q; fdata_d = fdata_q;
    rv_d = rv_q; rs_d = rs_q; cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    we = 1'b0; wa = ra; wd = '0; cmd_ready_o = 1'b0; root_clr = 1'b0;
    hx2 = 34'(hx_q >> 1); hy2 = 34'(hy_q >> 1); hz2 = 34'(hz_q >> 1);
    bx = 34'($signed(c_q.px)) > cx_q;
    by = 34'($signed(c_q.py)) > cy_q;
    bz = 34'($signed(c_q.pz)) > cz_q;
    unique case (st_q)
      BK_IDLE: begin
        cmd_ready_o = !ov_q;
        if (accept) begin
          lvl_d = '0; rv_d = '0; rs_d = ST_OK; st_d = BK_DONE;
          if (cmd_i.kind == KIND_CLEAR) begin
            root_clr = 1'b1; free_d = CntW'(1);
          end else if (cmd_i.kind != KIND_NOP) begin
            if (cmd_i.kind == KIND_LOOKUP) rv_d = empty_i;
            if (cmd_i.oob) rs_d = ST_OOB;
            else st_d = BK_READ;
          end
        end
      end
      BK_READ: begin
        oct_d = {bx, by, bz};
        cx_d = bx ? cx_q + hx2 : cx_q - hx2;
        cy_d = by ? cy_q + hy2 : cy_q - hy2;
        cz_d = bz ? cz_q + hz2 : cz_q - hz2;
        lvl_d = lvl_q + 1'b1;
        st_d = node_oob ? BK_DONE : BK_WAIT;
      end
      BK_WAIT: st_d = BK_DECIDE;
      BK_DECIDE: begin
        st_d = BK_DONE;
        if (c_q.kind == KIND_LOOKUP) begin
          if (rkind == SLOT_BRANCH) begin
            node_d = NodeW'(rdata); st_d = BK_READ;
          end else if (rkind == SLOT_LEAF) rv_d = rdata;
        end else if (rkind == SLOT_BRANCH) begin
          node_d = NodeW'(rdata); st_d = BK_READ;
        end else if (rkind == SLOT_LEAF && rdata == c_q.val) begin
          st_d = BK_DONE;
        end else if (32'(lvl_q) >= 32'(lim)) begin
          we = 1'b1; wd = {SLOT_LEAF, c_q.val};
        end else if (32'(free_q) >= NodeCount) begin
          rs_d = ST_FULL;
        end else begin
          fkind_d = (rkind == SLOT_LEAF) ? SLOT_LEAF : SLOT_NULL;
          fdata_d = (rkind == SLOT_LEAF) ? rdata : '0;
          fcnt_d = '0; st_d = BK_FILL;
        end
        if (st_d == BK_READ && 32'(lvl_q) >= MaxLevels) st_d = BK_DONE;
      end
      BK_FILL: begin
        we = 1'b1; wa = {free_q[NodeW-1:0], fcnt_q}; wd = {fkind_q, fdata_q};
        fcnt_d = fcnt_q + 3'd1;
        if (fcnt_q == 3'd7) st_d = BK_LINK;
      end
      BK_LINK: begin
        we = 1'b1; wd = {SLOT_BRANCH, 32'(free_q)};
        node_d = free_q[NodeW-1:0]; free_d = free_q + 1'b1;
        st_d = (32'(lvl_q) >= MaxLevels) ? BK_DONE : BK_READ;
      end
      BK_DONE: st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q <= cmd_i;
      cx_q <= 34'(cx_i); cy_q <= 34'(cy_i); cz_q <= 34'(cz_i);
      hx_q <= ex_i >> 1; hy_q <= ey_i >> 1; hz_q <= ez_i >> 1;
      node_q <= '0;
    end else begin
      if (st_q == BK_READ) begin
        hx_q <= hx_q >> 1; hy_q <= hy_q >> 1; hz_q <= hz_q >> 1;
      end
      cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; node_q <= node_d;
    end
    oct_q <= oct_d; fkind_q <= fkind_d; fdata_q <= fdata_d;
    if (st_q == BK_DONE) begin
      read_value_o <= rv_q; status_o <= rs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; free_q <= CntW'(1); root_vld_q <= '0; lvl_q <= '0;
      fcnt_q <= '0; rv_q <= '0; rs_q <= ST_OK; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; free_q <= free_d; fcnt_q <= fcnt_d; rv_q <= rv_d; rs_q <= rs_d;
      lvl_q <= lvl_d;
      if (root_clr) root_vld_q <= '0;
      else if (we && wa[AddrW-1:3] == '0) root_vld_q[wa[2:0]] <= 1'b1;
      if (st_q == BK_DONE) ov_q <= 1'b1;
      else if (out_valid && out_ready) ov_q <= 1'b0;
    end
  end

  assign out_valid = ov_q;

  `SOVS_ASSERT_IMPL(a_free_rng, clk_i, rst_ni, (free_q >= CntW'(1)))
  `SOVS_ASSERT_NEXT(a_fill_link, clk_i, rst_ni, (st_q == BK_FILL && fcnt_q == 3'd7),
                    (st_q == BK_LINK))
  `SOVS_ASSERT_IMPL(a_lvl_max, clk_i, rst_ni, (32'(lvl_q) <= MaxLevels))
endmodule

### hdl/sparse_octree_voxel_store_unit.sv
// Sparse octree voxel store: insert, lookup and clear of Q16.16 points.
// Item channel in, result channel out, config write channel.
// Usage:
//  - in_valid/in_ready take an item: kind, pos_x/y/z, store_value.
//  - out_valid/out_ready deliver read_value and status, one per item.
//  - cfg_valid/cfg_ready write register cfg_index with cfg_data while idle.
// Out-of-bounds, clear and no-op items skip the walk: from the queue the
// idle back end goes straight to the done state, which raises out_valid.
// A walk passes the READ, WAIT and DECIDE states per level, one child store
// read each, and each new branch passes FILL to write its eight children
// and LINK to link it in. The worst insert walks 16 levels and adds 15
// new branches. The back end handles one item at a time and takes the next
// item in the cycle after the result is accepted.
// A two-entry queue between front and back takes items while a walk runs.
// Reset empties the root and sets the pool pointer to one; no sweep.
// When the receiver stalls, the result holds and the back end waits;
// the queue still accepts up to two items.
module sparse_octree_voxel_store_unit import sovs_pkg::*; #(
  parameter int unsigned NodeCount = NodeCountDef,
  parameter int unsigned MaxLevels = MaxLevelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] store_value_i,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [31:0] read_value_o,
  output logic [1:0]        status_o,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  logic signed [31:0] cx_q, cy_q, cz_q, empty_q;
  logic [30:0] ex_q, ey_q, ez_q;
  logic [4:0]  depth_q;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0; empty_q <= '0;
      ex_q <= 31'd65536; ey_q <= 31'd65536; ez_q <= 31'd65536; depth_q <= 5'd8;
    end else if (cfg_valid) begin
      unique case (cfg_e'(cfg_index))
        CFG_CX:    cx_q <= cfg_data;
        CFG_CY:    cy_q <= cfg_data;
        CFG_CZ:    cz_q <= cfg_data;
        CFG_EX:    ex_q <= cfg_data[30:0];
        CFG_EY:    ey_q <= cfg_data[30:0];
        CFG_EZ:    ez_q <= cfg_data[30:0];
        CFG_DEPTH: depth_q <= cfg_data[4:0];
        CFG_EMPTY: empty_q <= cfg_data;
        default: ;
      endcase
    end
  end

  sovs_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .kind_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .store_value_i, .cx_i(cx_q), .cy_i(cy_q), .cz_i(cz_q), .ex_i(ex_q), .ey_i(ey_q),
    .ez_i(ez_q), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sovs_back #(.NodeCount(NodeCount), .MaxLevels(MaxLevels)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .cx_i(cx_q), .cy_i(cy_q), .cz_i(cz_q), .ex_i(ex_q), .ey_i(ey_q), .ez_i(ez_q),
    .depth_i(depth_q), .empty_i(empty_q), .out_valid, .out_ready, .read_value_o,
    .status_o
  );
endmodule
